### hw/rtl/assert_macros.svh
// Assertion macros for the file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/tsc_pkg.sv
// Shared constants and types of the triangle similarity compare core.
package tsc_pkg;

    localparam int COORD_BITS_DEF      = 16;
    localparam int RATIO_FRAC_BITS_DEF = 24;
    localparam int FIELD_W             = 16;
    localparam int THRESH_W            = 50;
    localparam int PDATA_W             = 64;
    localparam int PADDR_W             = 1;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 50'd28147;
    localparam logic [PADDR_W-1:0]  ADDR_THRESH  = 1'b0;

    // Control that travels alongside each pipeline stage.
    typedef struct packed {
        logic valid;
        logic degen;
    } ctl_t;

endpackage

### hw/rtl/tsc_side_sort.sv
// Squared side lengths of one triangle, sorted longest first.
module tsc_side_sort #(
    parameter int CW = tsc_pkg::COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tsc_pkg::ctl_t         ctl_in,
    input  logic [5:0][CW-1:0]    coord,
    output tsc_pkg::ctl_t         ctl_out,
    output logic [2*CW:0]         s_long,
    output logic [2*CW:0]         s_mid,
    output logic [2*CW:0]         s_short
);
    localparam int SW = 2 * CW + 1;

    tsc_pkg::ctl_t ctl_a_reg, ctl_b_reg, ctl_c_reg, ctl_d_reg;
    logic [5:0][CW-1:0]   diff_reg, diff_next;
    logic [5:0][2*CW-1:0] sq_reg;
    logic [2:0][SW-1:0]   side_reg;
    logic [SW-1:0] long_reg, mid_reg, short_reg;
    logic [SW-1:0] long_next, mid_next, short_next;
    logic g01, g02, g12;

    function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] p, input logic [CW-1:0] q);
        return (p >= q) ? (p - q) : (q - p);
    endfunction

    // Sides: a-b, a-c, b-c; x difference then y difference.
    always_comb
    begin
        diff_next[0] = abs_diff(coord[0], coord[2]);
        diff_next[1] = abs_diff(coord[1], coord[3]);
        diff_next[2] = abs_diff(coord[0], coord[4]);
        diff_next[3] = abs_diff(coord[1], coord[5]);
        diff_next[4] = abs_diff(coord[2], coord[4]);
        diff_next[5] = abs_diff(coord[3], coord[5]);
    end

    // The sort uses three comparisons side by side and a selection.
    always_comb
    begin
        g01 = side_reg[0] >= side_reg[1];
        g02 = side_reg[0] >= side_reg[2];
        g12 = side_reg[1] >= side_reg[2];
        if (g01 && g02)
            long_next = side_reg[0];
        else if (!g01 && g12)
            long_next = side_reg[1];
        else
            long_next = side_reg[2];
        if (!g01 && !g02)
            short_next = side_reg[0];
        else if (g01 && !g12)
            short_next = side_reg[1];
        else
            short_next = side_reg[2];
        if (g01 != g02)
            mid_next = side_reg[0];
        else if (g12 == g01)
            mid_next = side_reg[1];
        else
            mid_next = side_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
            ctl_c_reg <= '0;
            ctl_d_reg <= '0;
        end
        else
        begin
            ctl_a_reg <= ctl_in;
            ctl_b_reg <= ctl_a_reg;
            ctl_c_reg <= ctl_b_reg;
            ctl_d_reg <= '{valid: ctl_c_reg.valid, degen: (long_next == '0)};
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        for (int i = 0; i < 6; i++)
            sq_reg[i] <= diff_reg[i] * diff_reg[i];
        for (int j = 0; j < 3; j++)
            side_reg[j] <= {1'b0, sq_reg[2*j]} + {1'b0, sq_reg[2*j+1]};
        long_reg  <= long_next;
        mid_reg   <= mid_next;
        short_reg <= short_next;
    end

    assign ctl_out = ctl_d_reg;
    assign s_long  = long_reg;
    assign s_mid   = mid_reg;
    assign s_short = short_reg;
endmodule

### hw/rtl/tsc_ratio_div.sv
// Pipelined restoring divider: floor(num * 2^(2F) / den), one quotient bit per stage.
module tsc_ratio_div #(
    parameter int SW = 2 * tsc_pkg::COORD_BITS_DEF + 1,
    parameter int F  = tsc_pkg::RATIO_FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  tsc_pkg::ctl_t    ctl_in,
    input  logic [SW-1:0]    num,
    input  logic [SW-1:0]    den,
    output tsc_pkg::ctl_t    ctl_out,
    output logic [2*F:0]     quot
);
    localparam int QW = 2 * F + 1;
    localparam int N  = 2 * F;

    tsc_pkg::ctl_t   ctl_reg [0:N];
    logic [SW-1:0]   rem_reg [0:N];
    logic [SW-1:0]   den_reg [0:N];
    logic [QW-1:0]   q_reg   [0:N];
    logic            ge0;

    // Num never exceeds den, so the integer part is one only for equal values.
    assign ge0 = num >= den;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg[0] <= '0;
        else
            ctl_reg[0] <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= ge0 ? '0 : num;
        den_reg[0] <= den;
        q_reg[0]   <= {{(QW-1){1'b0}}, ge0};
    end

    for (genvar k = 1; k <= N; k++)
    begin : g_stage
        logic [SW:0] rs;
        logic [SW:0] diff;
        logic        ge;

        assign rs   = {rem_reg[k-1], 1'b0};
        assign ge   = rs >= {1'b0, den_reg[k-1]};
        assign diff = rs - {1'b0, den_reg[k-1]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[k] <= '0;
            else
                ctl_reg[k] <= ctl_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= ge ? diff[SW-1:0] : rs[SW-1:0];
            den_reg[k] <= den_reg[k-1];
            q_reg[k]   <= {q_reg[k-1][QW-2:0], ge};
        end
    end

    assign ctl_out = ctl_reg[N];
    assign quot    = q_reg[N];
endmodule

### hw/rtl/tsc_isqrt.sv
// Pipelined integer square root, one root bit per stage.
module tsc_isqrt #(
    parameter int F = tsc_pkg::RATIO_FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  tsc_pkg::ctl_t    ctl_in,
    input  logic [2*F:0]     n,
    output tsc_pkg::ctl_t    ctl_out,
    output logic [F:0]       root
);
    localparam int RW  = F + 1;
    localparam int PW  = 2 * F + 2;
    localparam int RMW = F + 4;

    tsc_pkg::ctl_t   ctl_reg  [0:F];
    logic [RMW-3:0]  rem_reg  [0:F];
    logic [RW-1:0]   root_reg [0:F];
    logic [PW-1:0]   n_reg    [0:F];

    for (genvar k = 0; k <= F; k++)
    begin : g_stage
        tsc_pkg::ctl_t  ctl_in_k;
        logic [RMW-3:0] rem_in;
        logic [RW-1:0]  root_in;
        logic [PW-1:0]  n_in;
        logic [RMW-1:0] cand;
        logic [RMW-1:0] trial;
        logic [RMW-1:0] diff;
        logic           ge;

        if (k == 0)
        begin : g_first
            assign ctl_in_k = ctl_in;
            assign rem_in   = '0;
            assign root_in  = '0;
            assign n_in     = {1'b0, n};
        end
        else
        begin : g_next
            assign ctl_in_k = ctl_reg[k-1];
            assign rem_in   = rem_reg[k-1];
            assign root_in  = root_reg[k-1];
            assign n_in     = n_reg[k-1];
        end

        assign cand  = {rem_in, n_in[PW-1:PW-2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign ge    = cand >= trial;
        assign diff  = cand - trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ctl_reg[k] <= '0;
            else
                ctl_reg[k] <= ctl_in_k;
        end

        // The remainder stays below 2*root+1, so its top two bits are always zero.
        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= ge ? diff[RMW-3:0] : cand[RMW-3:0];
            root_reg[k] <= {root_in[RW-2:0], ge};
            n_reg[k]    <= {n_in[PW-3:0], 2'b00};
        end
    end

    assign ctl_out = ctl_reg[F];
    assign root    = root_reg[F];
endmodule

### hw/rtl/tsc_dist.sv
// Squared distance of two similarity space points and the threshold test.
module tsc_dist #(
    parameter int F = tsc_pkg::RATIO_FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tsc_pkg::ctl_t                   ctl_in,
    input  logic [F:0]                      rx1,
    input  logic [F:0]                      ry1,
    input  logic [F:0]                      rx2,
    input  logic [F:0]                      ry2,
    input  logic [tsc_pkg::THRESH_W-1:0]    threshold,
    output tsc_pkg::ctl_t                   ctl_out,
    output logic                            is_match,
    output logic [tsc_pkg::THRESH_W-1:0]    distance_sq
);
    localparam int RW = F + 1;
    localparam int DW = 2 * F + 2;

    tsc_pkg::ctl_t ctl_a_reg, ctl_b_reg, ctl_c_reg;
    logic [RW-1:0]   dx_reg, dy_reg;
    logic [2*RW-1:0] sqx_reg, sqy_reg;
    logic [2*RW:0]   sum;
    logic [tsc_pkg::THRESH_W-1:0] dist_next, dist_reg;
    logic match_reg;

    // The sum is at most 2^(2F+1), so DW bits hold it.
    assign sum       = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign dist_next = ctl_b_reg.degen ? '0
                     : {{(tsc_pkg::THRESH_W-DW){1'b0}}, sum[DW-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
            ctl_c_reg <= '0;
        end
        else
        begin
            ctl_a_reg <= ctl_in;
            ctl_b_reg <= ctl_a_reg;
            ctl_c_reg <= ctl_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg    <= (rx1 >= rx2) ? (rx1 - rx2) : (rx2 - rx1);
        dy_reg    <= (ry1 >= ry2) ? (ry1 - ry2) : (ry2 - ry1);
        sqx_reg   <= dx_reg * dx_reg;
        sqy_reg   <= dy_reg * dy_reg;
        dist_reg  <= dist_next;
        match_reg <= !ctl_b_reg.degen && (dist_next < threshold);
    end

    assign ctl_out     = ctl_c_reg;
    assign is_match    = match_reg;
    assign distance_sq = dist_reg;
endmodule

### hw/rtl/triangle_similarity_compare_core.sv
// Top level of the triangle similarity compare core.
//
// A transaction carries two triangles, six unsigned Q12.4 coordinates each,
// and is accepted at a rising clock edge where start is high and busy is low.
// busy is held low: the pipeline takes a new transaction in every cycle.
// Each triangle is reduced to its sorted squared sides, mapped to the point
// (middle/longest, shortest/longest) of similarity space with RATIO_FRAC_BITS
// fraction bits, and the squared distance of the two points is compared with
// match_threshold_sq.
// The pipeline runs in order: sides and sort, the one-bit-per-stage divider,
// the one-bit-per-stage square root, and distance and compare.
// Throughput is one transaction per cycle.
// The result is shown for exactly one cycle, marked by done. The receiver
// cannot stall, so no back pressure exists anywhere in the pipeline.
// The APB port holds match_threshold_sq at byte address 0 (64-bit data). The
// user must write it only while the pipeline is empty; the block does not
// enforce this. Reset empties the pipeline and resets the threshold.
`include "assert_macros.svh"

module triangle_similarity_compare_core #(
    parameter int COORD_BITS      = tsc_pkg::COORD_BITS_DEF,
    parameter int RATIO_FRAC_BITS = tsc_pkg::RATIO_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [tsc_pkg::FIELD_W-1:0]       first_ax,
    input  logic [tsc_pkg::FIELD_W-1:0]       first_ay,
    input  logic [tsc_pkg::FIELD_W-1:0]       first_bx,
    input  logic [tsc_pkg::FIELD_W-1:0]       first_by,
    input  logic [tsc_pkg::FIELD_W-1:0]       first_cx,
    input  logic [tsc_pkg::FIELD_W-1:0]       first_cy,
    input  logic [tsc_pkg::FIELD_W-1:0]       second_ax,
    input  logic [tsc_pkg::FIELD_W-1:0]       second_ay,
    input  logic [tsc_pkg::FIELD_W-1:0]       second_bx,
    input  logic [tsc_pkg::FIELD_W-1:0]       second_by,
    input  logic [tsc_pkg::FIELD_W-1:0]       second_cx,
    input  logic [tsc_pkg::FIELD_W-1:0]       second_cy,
    output logic                              done,
    output logic                              is_match,
    output logic                              degenerate,
    output logic [tsc_pkg::THRESH_W-1:0]      distance_sq,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tsc_pkg::PADDR_W-1:0]       paddr,
    input  logic [tsc_pkg::PDATA_W-1:0]       pwdata,
    output logic [tsc_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);
    // Coordinates use only the low COORD_BITS bits of each 16-bit field, at most all 16.
    localparam int CW = (COORD_BITS < tsc_pkg::FIELD_W) ? COORD_BITS : tsc_pkg::FIELD_W;
    localparam int SW = 2 * CW + 1;
    localparam int F  = RATIO_FRAC_BITS;

    logic [tsc_pkg::THRESH_W-1:0] thresh_reg, thresh_next;
    logic cfg_write;

    tsc_pkg::ctl_t ctl_in, ctl_t1, ctl_t2, ctl_div, ctl_sqrt, ctl_fin;
    tsc_pkg::ctl_t ctl_sorted;
    logic [5:0][CW-1:0] coord1, coord2;
    logic [SW-1:0] long1, mid1, short1, long2, mid2, short2;
    logic [2*F:0]  qx1, qy1, qx2, qy2;
    logic [F:0]    rx1, ry1, rx2, ry2;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign ctl_in = '{valid: start, degen: 1'b0};

    // Configuration: a single 50-bit register, written in the APB access phase.
    assign cfg_write   = psel && penable && pwrite && pready && (paddr == tsc_pkg::ADDR_THRESH);
    assign thresh_next = cfg_write ? pwdata[tsc_pkg::THRESH_W-1:0] : thresh_reg;
    assign prdata      = (paddr == tsc_pkg::ADDR_THRESH)
                       ? {{(tsc_pkg::PDATA_W-tsc_pkg::THRESH_W){1'b0}}, thresh_reg}
                       : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thresh_reg <= tsc_pkg::THRESH_RESET;
        else
            thresh_reg <= thresh_next;
    end

    assign coord1 = {first_cy[CW-1:0], first_cx[CW-1:0], first_by[CW-1:0],
                     first_bx[CW-1:0], first_ay[CW-1:0], first_ax[CW-1:0]};
    assign coord2 = {second_cy[CW-1:0], second_cx[CW-1:0], second_by[CW-1:0],
                     second_bx[CW-1:0], second_ay[CW-1:0], second_ax[CW-1:0]};

    // Both triangles run in lockstep; the first one carries the valid bit.
    tsc_side_sort #(.CW(CW)) u_sort1 (
        .clk(clk), .rst_n(rst_n), .ctl_in(ctl_in), .coord(coord1),
        .ctl_out(ctl_t1), .s_long(long1), .s_mid(mid1), .s_short(short1)
    );

    tsc_side_sort #(.CW(CW)) u_sort2 (
        .clk(clk), .rst_n(rst_n), .ctl_in(ctl_in), .coord(coord2),
        .ctl_out(ctl_t2), .s_long(long2), .s_mid(mid2), .s_short(short2)
    );

    // A degenerate pair still flows through; its ratios are ignored at the end.
    assign ctl_sorted = '{valid: ctl_t1.valid, degen: ctl_t1.degen || ctl_t2.degen};

    tsc_ratio_div #(.SW(SW), .F(F)) u_div_x1 (
        .clk(clk), .rst_n(rst_n), .ctl_in(ctl_sorted), .num(mid1), .den(long1),
        .ctl_out(ctl_div), .quot(qx1)
    );

    tsc_ratio_div #(.SW(SW), .F(F)) u_div_y1 (
        .clk(clk), .rst_n(rst_n), .ctl_in(ctl_sorted), .num(short1), .den(long1),
        .ctl_out(), .quot(qy1)
    );

    tsc_ratio_div #(.SW(SW), .F(F)) u_div_x2 (
        .clk(clk), .rst_n(rst_n), .ctl_in(ctl_sorted), .num(mid2), .den(long2),
        .ctl_out(), .quot(qx2)
    );

    tsc_ratio_div #(.SW(SW), .F(F)) u_div_y2 (
        .clk(clk), .rst_n(rst_n), .ctl_in(ctl_sorted), .num(short2), .den(long2),
        .ctl_out(), .quot(qy2)
    );

    tsc_isqrt #(.F(F)) u_sqrt_x1 (
        .clk(clk), .rst_n(rst_n), .ctl_in(ctl_div), .n(qx1), .ctl_out(ctl_sqrt), .root(rx1)
    );

    tsc_isqrt #(.F(F)) u_sqrt_y1 (
        .clk(clk), .rst_n(rst_n), .ctl_in(ctl_div), .n(qy1), .ctl_out(), .root(ry1)
    );

    tsc_isqrt #(.F(F)) u_sqrt_x2 (
        .clk(clk), .rst_n(rst_n), .ctl_in(ctl_div), .n(qx2), .ctl_out(), .root(rx2)
    );

    tsc_isqrt #(.F(F)) u_sqrt_y2 (
        .clk(clk), .rst_n(rst_n), .ctl_in(ctl_div), .n(qy2), .ctl_out(), .root(ry2)
    );

    tsc_dist #(.F(F)) u_dist (
        .clk(clk), .rst_n(rst_n), .ctl_in(ctl_sqrt),
        .rx1(rx1), .ry1(ry1), .rx2(rx2), .ry2(ry2), .threshold(thresh_reg),
        .ctl_out(ctl_fin), .is_match(is_match), .distance_sq(distance_sq)
    );

    assign done       = ctl_fin.valid;
    assign degenerate = ctl_fin.degen;

    // A degenerate result never matches and always reports zero distance.
    `ASSERT_ALWAYS(a_degen_no_match, !(done && degenerate && is_match),
                   "degenerate result reported as match")
    `ASSERT_ALWAYS(a_degen_zero_dist, !(done && degenerate) || (distance_sq == '0),
                   "degenerate result with nonzero distance")
    // A match means the distance really is below the threshold.
    `ASSERT_ALWAYS(a_match_below, !(done && is_match) || (distance_sq < thresh_reg),
                   "match reported with distance not below threshold")
    // A completed write lands in the threshold register.
    `ASSERT_NEXT(a_cfg_write, cfg_write,
                 thresh_reg == $past(pwdata[tsc_pkg::THRESH_W-1:0]),
                 "threshold write lost")
endmodule
